FILE: hw/rtl/analog_stick_conditioner_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the analog stick conditioner
// Shared concurrent checks, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ANALOG_STICK_CONDITIONER_TOP_MACROS_SVH
`define ANALOG_STICK_CONDITIONER_TOP_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge
`define ASC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge
`define ASC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/asc_pkg.sv
// ---------------------------------------------------------------------------
// Analog stick conditioner package
// Widths, reset values and codes shared by the conditioner RTL.
// ---------------------------------------------------------------------------
package asc_pkg;

    // Default parameter values
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int HOLD_MAX_DEF    = 255;

    // Fixed field widths
    localparam int DZ_W       = 10;
    localparam int THR_W      = 11;
    localparam int HOLD_BITS  = 8;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    // Configuration reset values
    localparam logic [DZ_W-1:0]  DZ_RESET  = DZ_W'(10);
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(10);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THRESH = 1'b1;

    // Command codes
    localparam logic CMD_SAMPLE    = 1'b0;
    localparam logic CMD_CALIBRATE = 1'b1;

    // Button pin level when pressed (active low)
    localparam logic BUTTON_DOWN = 1'b0;

endpackage

FILE: hw/rtl/analog_stick_conditioner_top.sv
// ---------------------------------------------------------------------------
// Analog stick conditioner, top level
// Centre calibration, dead zone and move detection, button edges and hold count.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries cmd, sample_x, sample_y and
//   button_level. A transaction completes when in_valid is high and in_stall
//   is low. Output channel (out_valid / out_stall) carries one result per
//   input transaction, in order.
//   Configuration: cfg_we writes cfg_data into the register chosen by
//   cfg_index (0 = centre dead zone, 1 = move threshold); write only when idle.
//   Data path: an accepted item lands in the input register, then its result
//   is computed in one pass and held in the result register, which drives
//   out_valid.
//   Throughput: one item per cycle while out_stall is low, set by the single
//   compute pass between the input register and the result register.
//   Stall: while out_stall holds a pending result the input register still
//   takes one more item, after which in_stall rises; nothing is dropped.
//   Reset: both registers empty, centre at half scale, positions, deltas and
//   hold count zero, dead zone and threshold at 10.
// ---------------------------------------------------------------------------
`include "analog_stick_conditioner_top_macros.svh"

module analog_stick_conditioner_top
    import asc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int HOLD_MAX    = HOLD_MAX_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic [SAMPLE_BITS-1:0]        sample_x,
    input  logic [SAMPLE_BITS-1:0]        sample_y,
    input  logic                          button_level,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS:0]   pos_x,
    output logic signed [SAMPLE_BITS:0]   pos_y,
    output logic signed [SAMPLE_BITS+1:0] delta_x,
    output logic signed [SAMPLE_BITS+1:0] delta_y,
    output logic                          at_center,
    output logic                          moved,
    output logic                          pressed_edge,
    output logic                          released_edge,
    output logic [HOLD_BITS-1:0]          hold_count
);

    localparam int POS_W      = SAMPLE_BITS + 1;
    localparam int DELTA_W    = SAMPLE_BITS + 2;
    localparam int HOLD_W     = $clog2(HOLD_MAX + 1);
    localparam int HOLD_EXT_W = (HOLD_W > HOLD_BITS) ? HOLD_W : HOLD_BITS;
    localparam int DZC_W      = (POS_W > DZ_W) ? POS_W : DZ_W;
    localparam int THC_W      = (DELTA_W > THR_W) ? DELTA_W : THR_W;
    localparam logic [SAMPLE_BITS-1:0] CENTRE_RESET = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [HOLD_W-1:0]      HOLD_LIMIT   = HOLD_W'(HOLD_MAX);

    // configuration registers
    logic [DZ_W-1:0]  dead_zone_reg;
    logic [THR_W-1:0] move_thresh_reg;

    // input register
    logic                   in_valid_reg;
    logic                   in_cmd_reg;
    logic [SAMPLE_BITS-1:0] in_sx_reg;
    logic [SAMPLE_BITS-1:0] in_sy_reg;
    logic                   in_button_reg;

    // conditioner state
    logic [SAMPLE_BITS-1:0]    center_x_reg, center_x_next;
    logic [SAMPLE_BITS-1:0]    center_y_reg, center_y_next;
    logic signed [POS_W-1:0]   last_pos_x_reg, last_pos_x_next;
    logic signed [POS_W-1:0]   last_pos_y_reg, last_pos_y_next;
    logic signed [DELTA_W-1:0] last_delta_x_reg, last_delta_x_next;
    logic signed [DELTA_W-1:0] last_delta_y_reg, last_delta_y_next;
    logic [HOLD_W-1:0]         hold_counter_reg, hold_counter_next;

    // result register
    logic                      out_valid_reg;
    logic signed [POS_W-1:0]   out_pos_x_reg;
    logic signed [POS_W-1:0]   out_pos_y_reg;
    logic signed [DELTA_W-1:0] out_delta_x_reg;
    logic signed [DELTA_W-1:0] out_delta_y_reg;
    logic                      out_center_reg;
    logic                      out_moved_reg;
    logic                      out_pressed_reg;
    logic                      out_released_reg;
    logic [HOLD_BITS-1:0]      out_hold_reg;

    // datapath signals
    logic                      out_free;
    logic                      advance;
    logic                      in_take;
    logic                      btn_down;
    logic                      pressed_next;
    logic                      released_next;
    logic                      centered_next;
    logic                      moved_next;
    logic signed [POS_W-1:0]   px_new;
    logic signed [POS_W-1:0]   py_new;
    logic [POS_W-1:0]          pos_mag_x;
    logic [POS_W-1:0]          pos_mag_y;
    logic [DELTA_W-1:0]        dlt_mag_x;
    logic [DELTA_W-1:0]        dlt_mag_y;
    logic [HOLD_EXT_W-1:0]     hold_ext;

    // handshake: result register frees when empty or being taken
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg   <= DZ_RESET;
            move_thresh_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEAD_ZONE:   dead_zone_reg   <= cfg_data[DZ_W-1:0];
                CFG_MOVE_THRESH: move_thresh_reg <= cfg_data[THR_W-1:0];
                default:         ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_valid_reg || advance)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg    <= cmd;
            in_sx_reg     <= sample_x;
            in_sy_reg     <= sample_y;
            in_button_reg <= button_level;
        end
    end

    // single-pass update of centre, position, delta and hold counter
    always_comb
    begin
        center_x_next     = center_x_reg;
        center_y_next     = center_y_reg;
        last_pos_x_next   = last_pos_x_reg;
        last_pos_y_next   = last_pos_y_reg;
        last_delta_x_next = last_delta_x_reg;
        last_delta_y_next = last_delta_y_reg;
        hold_counter_next = hold_counter_reg;
        pressed_next      = 1'b0;
        released_next     = 1'b0;
        btn_down          = (in_button_reg == BUTTON_DOWN);
        px_new = $signed({1'b0, in_sx_reg}) - $signed({1'b0, center_x_reg});
        py_new = $signed({1'b0, in_sy_reg}) - $signed({1'b0, center_y_reg});

        unique case (in_cmd_reg)
            CMD_CALIBRATE:
            begin
                center_x_next   = in_sx_reg;
                center_y_next   = in_sy_reg;
                last_pos_x_next = '0;
                last_pos_y_next = '0;
            end
            default:
            begin
                last_delta_x_next = DELTA_W'(px_new) - DELTA_W'(last_pos_x_reg);
                last_delta_y_next = DELTA_W'(py_new) - DELTA_W'(last_pos_y_reg);
                last_pos_x_next   = px_new;
                last_pos_y_next   = py_new;
                if (btn_down)
                begin
                    pressed_next = (hold_counter_reg == '0);
                    if (hold_counter_reg < HOLD_LIMIT)
                    begin
                        hold_counter_next = hold_counter_reg + HOLD_W'(1);
                    end
                end
                else
                begin
                    released_next     = (hold_counter_reg != '0);
                    hold_counter_next = '0;
                end
            end
        endcase

        // magnitudes; values never reach the most negative code
        pos_mag_x = last_pos_x_next[POS_W-1] ? POS_W'(-last_pos_x_next) : last_pos_x_next;
        pos_mag_y = last_pos_y_next[POS_W-1] ? POS_W'(-last_pos_y_next) : last_pos_y_next;
        dlt_mag_x = last_delta_x_next[DELTA_W-1] ? DELTA_W'(-last_delta_x_next)
                                                 : last_delta_x_next;
        dlt_mag_y = last_delta_y_next[DELTA_W-1] ? DELTA_W'(-last_delta_y_next)
                                                 : last_delta_y_next;

        centered_next = (DZC_W'(pos_mag_x) <= DZC_W'(dead_zone_reg)) &&
                        (DZC_W'(pos_mag_y) <= DZC_W'(dead_zone_reg));
        moved_next    = (THC_W'(dlt_mag_x) >= THC_W'(move_thresh_reg)) ||
                        (THC_W'(dlt_mag_y) >= THC_W'(move_thresh_reg));
        hold_ext      = HOLD_EXT_W'(hold_counter_next);
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= CENTRE_RESET;
            center_y_reg     <= CENTRE_RESET;
            last_pos_x_reg   <= '0;
            last_pos_y_reg   <= '0;
            last_delta_x_reg <= '0;
            last_delta_y_reg <= '0;
            hold_counter_reg <= '0;
        end
        else if (advance)
        begin
            center_x_reg     <= center_x_next;
            center_y_reg     <= center_y_next;
            last_pos_x_reg   <= last_pos_x_next;
            last_pos_y_reg   <= last_pos_y_next;
            last_delta_x_reg <= last_delta_x_next;
            last_delta_y_reg <= last_delta_y_next;
            hold_counter_reg <= hold_counter_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pos_x_reg    <= last_pos_x_next;
            out_pos_y_reg    <= last_pos_y_next;
            out_delta_x_reg  <= last_delta_x_next;
            out_delta_y_reg  <= last_delta_y_next;
            out_center_reg   <= centered_next;
            out_moved_reg    <= moved_next;
            out_pressed_reg  <= pressed_next;
            out_released_reg <= released_next;
            out_hold_reg     <= hold_ext[HOLD_BITS-1:0];
        end
    end

    // output ports
    assign out_valid     = out_valid_reg;
    assign pos_x         = out_pos_x_reg;
    assign pos_y         = out_pos_y_reg;
    assign delta_x       = out_delta_x_reg;
    assign delta_y       = out_delta_y_reg;
    assign at_center     = out_center_reg;
    assign moved         = out_moved_reg;
    assign pressed_edge  = out_pressed_reg;
    assign released_edge = out_released_reg;
    assign hold_count    = out_hold_reg;

    // checks
    `ASC_ASSERT_NOW(a_stall_only_when_full, in_stall,
                    in_valid_reg && out_valid_reg && out_stall,
                    "input stalled while the result register could drain")
    `ASC_ASSERT_NOW(a_edges_exclusive, out_valid_reg,
                    !(out_pressed_reg && out_released_reg),
                    "press and release edge flagged in one result")
    `ASC_ASSERT_NEXT(a_calibrate_centres, advance && (in_cmd_reg == CMD_CALIBRATE),
                     (out_pos_x_reg == '0) && (out_pos_y_reg == '0) && out_center_reg
                     && !out_pressed_reg && !out_released_reg,
                     "calibrate transaction did not give a centred result")
    `ASC_ASSERT_NEXT(a_press_starts_count, advance && pressed_next,
                     out_hold_reg == HOLD_BITS'(1),
                     "press edge without hold count of one")
    `ASC_ASSERT_NEXT(a_release_clears_count, advance && released_next,
                     out_hold_reg == '0,
                     "release edge without cleared hold count")
    `ASC_ASSERT_NOW(a_hold_within_limit, 1'b1, hold_counter_reg <= HOLD_LIMIT,
                    "hold counter beyond its limit")

endmodule

FILE: dv/analog_stick_conditioner_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Analog stick conditioner result checker
// Watches the configuration port and both channels. It predicts the result
// of every accepted input transaction and compares each output transaction,
// field by field, with the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module analog_stick_conditioner_checker
    import asc_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [CFG_IDX_W-1:0]              cfg_index,
    input  logic [CFG_DATA_W-1:0]             cfg_data,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              cmd,
    input  logic [SAMPLE_BITS_DEF-1:0]        sample_x,
    input  logic [SAMPLE_BITS_DEF-1:0]        sample_y,
    input  logic                              button_level,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [SAMPLE_BITS_DEF:0]   pos_x,
    input  logic signed [SAMPLE_BITS_DEF:0]   pos_y,
    input  logic signed [SAMPLE_BITS_DEF+1:0] delta_x,
    input  logic signed [SAMPLE_BITS_DEF+1:0] delta_y,
    input  logic                              at_center,
    input  logic                              moved,
    input  logic                              pressed_edge,
    input  logic                              released_edge,
    input  logic [HOLD_BITS-1:0]              hold_count,
    output int                                mismatch_count,
    output int                                pending_count
);

    localparam int SAMPLE_W = SAMPLE_BITS_DEF;
    localparam int POS_W    = SAMPLE_W + 1;
    localparam int DELTA_W  = SAMPLE_W + 2;

    typedef struct {
        logic signed [SAMPLE_W:0]   pos_x;
        logic signed [SAMPLE_W:0]   pos_y;
        logic signed [SAMPLE_W+1:0] delta_x;
        logic signed [SAMPLE_W+1:0] delta_y;
        logic                       at_center;
        logic                       moved;
        logic                       pressed_edge;
        logic                       released_edge;
        logic [HOLD_BITS-1:0]       hold_count;
    } stick_result_t;

    stick_result_t expected_results[$];
    stick_result_t oldest;

    // Predicted conditioner state
    logic [SAMPLE_W-1:0]        centre_x;
    logic [SAMPLE_W-1:0]        centre_y;
    logic signed [SAMPLE_W:0]   last_pos_x;
    logic signed [SAMPLE_W:0]   last_pos_y;
    logic signed [SAMPLE_W+1:0] last_delta_x;
    logic signed [SAMPLE_W+1:0] last_delta_y;
    logic [HOLD_BITS-1:0]       held_updates;
    logic [DZ_W-1:0]            dead_zone;
    logic [THR_W-1:0]           move_thresh;

    int result_number = 0;
    int errors        = 0;

    assign mismatch_count = errors;

    function automatic int magnitude_of(int v);
        return (v < 0) ? -v : v;
    endfunction

    // Advances the predicted state by one item and returns its result
    function automatic stick_result_t condition_sample(logic c, logic [SAMPLE_W-1:0] sx,
                                                       logic [SAMPLE_W-1:0] sy, logic btn);
        stick_result_t r;
        int px;
        int py;
        r.pressed_edge  = 1'b0;
        r.released_edge = 1'b0;
        if (c == CMD_CALIBRATE)
        begin
            // new centre, position back to zero, delta and hold count kept
            centre_x   = sx;
            centre_y   = sy;
            last_pos_x = '0;
            last_pos_y = '0;
        end
        else
        begin
            px           = int'(sx) - int'(centre_x);
            py           = int'(sy) - int'(centre_y);
            last_delta_x = DELTA_W'(px - int'(last_pos_x));
            last_delta_y = DELTA_W'(py - int'(last_pos_y));
            last_pos_x   = POS_W'(px);
            last_pos_y   = POS_W'(py);
            if (btn == BUTTON_DOWN)
            begin
                if (held_updates == 0)
                    r.pressed_edge = 1'b1;
                if (held_updates < HOLD_MAX_DEF)
                    held_updates = held_updates + 1'b1;
            end
            else
            begin
                if (held_updates != 0)
                    r.released_edge = 1'b1;
                held_updates = '0;
            end
        end
        r.pos_x      = last_pos_x;
        r.pos_y      = last_pos_y;
        r.delta_x    = last_delta_x;
        r.delta_y    = last_delta_y;
        r.at_center  = (magnitude_of(int'(last_pos_x)) <= int'(dead_zone)) &&
                       (magnitude_of(int'(last_pos_y)) <= int'(dead_zone));
        r.moved      = (magnitude_of(int'(last_delta_x)) >= int'(move_thresh)) ||
                       (magnitude_of(int'(last_delta_y)) >= int'(move_thresh));
        r.hold_count = held_updates;
        return r;
    endfunction

    // One line per mismatch
    task automatic note_mismatch(string what);
        $display("%0t: result %0d: %s", $time, result_number, what);
        errors++;
    endtask

    task automatic check_field(string name, logic signed [12:0] got,
                               logic signed [12:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    // Configuration tracking, comparison of results, prediction of new items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_x      = SAMPLE_W'(1 << (SAMPLE_W - 1));
            centre_y      = SAMPLE_W'(1 << (SAMPLE_W - 1));
            last_pos_x    = '0;
            last_pos_y    = '0;
            last_delta_x  = '0;
            last_delta_y  = '0;
            held_updates  = '0;
            dead_zone     = DZ_RESET;
            move_thresh   = THR_RESET;
            expected_results.delete();
            pending_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_DEAD_ZONE)
                    dead_zone = cfg_data[DZ_W-1:0];
                else if (cfg_index == CFG_MOVE_THRESH)
                    move_thresh = cfg_data[THR_W-1:0];
            end

            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    note_mismatch("result transaction with no item outstanding");
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("pos_x", pos_x, oldest.pos_x);
                    check_field("pos_y", pos_y, oldest.pos_y);
                    check_field("delta_x", delta_x, oldest.delta_x);
                    check_field("delta_y", delta_y, oldest.delta_y);
                    check_field("at_center", at_center, oldest.at_center);
                    check_field("moved", moved, oldest.moved);
                    check_field("pressed_edge", pressed_edge, oldest.pressed_edge);
                    check_field("released_edge", released_edge, oldest.released_edge);
                    check_field("hold_count", hold_count, oldest.hold_count);
                end
                result_number++;
            end

            if (in_valid && !in_stall)
                expected_results.push_back(condition_sample(cmd, sample_x, sample_y,
                                                            button_level));

            pending_count <= expected_results.size();
        end
    end

endmodule

FILE: dv/analog_stick_conditioner_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Analog stick conditioner testbench
// Directed items at the field extremes and the dead zone and threshold
// boundaries, then phases of random stick and button traffic under several
// dead zone and threshold settings, with random idling on both channels,
// one quiet phase and one long output hold-off. A separate checker predicts
// and compares every result.
// ---------------------------------------------------------------------------
module analog_stick_conditioner_top_test;
    import asc_pkg::*;

    localparam int   SAMPLE_W        = SAMPLE_BITS_DEF;
    localparam int   SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
    localparam int   SAMPLE_MID      = 1 << (SAMPLE_W - 1);
    localparam int   CFG_DATA_MAX    = (1 << CFG_DATA_W) - 1;
    localparam int   CYCLE_LIMIT     = 200000;
    localparam int   PHASE_ITEMS     = 260;
    localparam int   HOLD_OFF_CYCLES = 80;
    localparam logic BUTTON_UP       = ~BUTTON_DOWN;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index    = CFG_DEAD_ZONE;
    logic [CFG_DATA_W-1:0]         cfg_data     = '0;
    logic                          in_valid     = 1'b0;
    logic                          cmd          = CMD_SAMPLE;
    logic [SAMPLE_W-1:0]           sample_x     = '0;
    logic [SAMPLE_W-1:0]           sample_y     = '0;
    logic                          button_level = BUTTON_UP;
    logic                          out_stall    = 1'b0;
    logic                          in_stall;
    logic                          out_valid;
    logic signed [SAMPLE_W:0]      pos_x;
    logic signed [SAMPLE_W:0]      pos_y;
    logic signed [SAMPLE_W+1:0]    delta_x;
    logic signed [SAMPLE_W+1:0]    delta_y;
    logic                          at_center;
    logic                          moved;
    logic                          pressed_edge;
    logic                          released_edge;
    logic [HOLD_BITS-1:0]          hold_count;
    int                            mismatch_count;
    int                            pending_count;

    // Traffic shaping shared by the driver and the output stall process
    logic quiet_phase   = 1'b0;
    logic hold_off_req  = 1'b0;
    logic hold_off_done = 1'b0;
    int   hold_off_cnt  = 0;
    int   cycle_count   = 0;

    // Stimulus view of the stick: last centre and last sample, button run
    int   cur_dz        = DZ_RESET;
    int   cur_thr       = THR_RESET;
    int   aim_x         = SAMPLE_MID;
    int   aim_y         = SAMPLE_MID;
    int   last_x        = SAMPLE_MID;
    int   last_y        = SAMPLE_MID;
    int   run_left      = 0;
    logic btn_down      = 1'b0;
    logic long_press_due = 1'b0;

    analog_stick_conditioner_top uut (.*);

    analog_stick_conditioner_checker checker_i (.*);

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("analog_stick_conditioner_top_test NOT OK");
            $finish;
        end
    end

    // Output stall: one long hold-off on request, otherwise random or none
    always @(posedge clk)
    begin
        if (hold_off_req && !hold_off_done)
        begin
            out_stall    <= 1'b1;
            hold_off_cnt <= hold_off_cnt + 1;
            if (hold_off_cnt == HOLD_OFF_CYCLES - 1)
                hold_off_done <= 1'b1;
        end
        else if (quiet_phase)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 23);
    end

    function automatic int near_value(int base, int spread);
        int v;
        v = base - spread + int'($urandom_range(2 * spread));
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return v;
    endfunction

    // Offers one transaction and returns at the edge where it is accepted
    task automatic send_item(logic c, int sx, int sy, logic btn);
        while (!quiet_phase && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= c;
        sample_x     <= SAMPLE_W'(sx);
        sample_y     <= SAMPLE_W'(sy);
        button_level <= btn;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drains every outstanding result, plus a margin for the pipeline
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(int dz_word, int thr_word);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEAD_ZONE;
        cfg_data  <= CFG_DATA_W'(dz_word);
        @(posedge clk);
        cfg_index <= CFG_MOVE_THRESH;
        cfg_data  <= CFG_DATA_W'(thr_word);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_dz    = dz_word & ((1 << DZ_W) - 1);
        cur_thr   = thr_word & ((1 << THR_W) - 1);
    endtask

    // Random traffic: mostly button runs with samples around the centre or
    // stepping near the threshold, some calibrations and full-range noise
    task automatic run_phase(int count);
        int r;
        int sx;
        int sy;
        int dz_spread;
        int thr_spread;
        for (int i = 0; i < count; i++)
        begin
            r          = $urandom_range(99);
            dz_spread  = (cur_dz + 2 > SAMPLE_MAX) ? SAMPLE_MAX : cur_dz + 2;
            thr_spread = (cur_thr + 2 > SAMPLE_MAX) ? SAMPLE_MAX : cur_thr + 2;
            if (r < 8)
            begin
                if ($urandom_range(99) < 60)
                begin
                    aim_x = near_value(SAMPLE_MID, 40);
                    aim_y = near_value(SAMPLE_MID, 40);
                end
                else
                begin
                    aim_x = $urandom_range(SAMPLE_MAX);
                    aim_y = $urandom_range(SAMPLE_MAX);
                end
                last_x = aim_x;
                last_y = aim_y;
                send_item(CMD_CALIBRATE, aim_x, aim_y, 1'($urandom_range(1)));
            end
            else
            begin
                // button run bookkeeping
                if (run_left == 0)
                begin
                    btn_down = !btn_down;
                    if (btn_down && long_press_due)
                    begin
                        run_left       = $urandom_range(300, 260);
                        long_press_due = 1'b0;
                    end
                    else
                        run_left = $urandom_range(10, 1);
                end
                run_left--;
                if (r < 20)
                begin
                    sx = $urandom_range(SAMPLE_MAX);
                    sy = $urandom_range(SAMPLE_MAX);
                end
                else if ($urandom_range(1))
                begin
                    sx = near_value(aim_x, dz_spread);
                    sy = near_value(aim_y, dz_spread);
                end
                else
                begin
                    sx = near_value(last_x, thr_spread);
                    sy = near_value(last_y, thr_spread);
                end
                last_x = sx;
                last_y = sy;
                // an occasional glitch on the button pin
                if ($urandom_range(99) < 3)
                    send_item(CMD_SAMPLE, sx, sy, 1'($urandom_range(1)));
                else
                    send_item(CMD_SAMPLE, sx, sy, btn_down ? BUTTON_DOWN : BUTTON_UP);
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset dead zone and threshold of 10
        send_item(CMD_SAMPLE, 512, 512, BUTTON_UP);       // at the centre
        send_item(CMD_SAMPLE, 522, 502, BUTTON_UP);       // on the dead zone edge
        send_item(CMD_SAMPLE, 523, 512, BUTTON_UP);       // just outside it
        send_item(CMD_SAMPLE, 0, 0, BUTTON_DOWN);         // press edge, low extreme
        send_item(CMD_SAMPLE, SAMPLE_MAX, SAMPLE_MAX, BUTTON_DOWN);
        send_item(CMD_SAMPLE, SAMPLE_MAX, SAMPLE_MAX, BUTTON_UP);   // release edge
        send_item(CMD_SAMPLE, SAMPLE_MAX, 0, BUTTON_UP);
        send_item(CMD_CALIBRATE, 0, 0, BUTTON_DOWN);      // button ignored
        send_item(CMD_SAMPLE, SAMPLE_MAX, SAMPLE_MAX, BUTTON_DOWN);
        send_item(CMD_CALIBRATE, SAMPLE_MAX, SAMPLE_MAX, BUTTON_UP);
        send_item(CMD_SAMPLE, 0, 0, BUTTON_UP);           // most negative position
        send_item(CMD_SAMPLE, 9, 0, BUTTON_UP);           // delta just under threshold
        send_item(CMD_SAMPLE, 19, 0, BUTTON_UP);          // delta on the threshold
        send_item(CMD_CALIBRATE, SAMPLE_MID, SAMPLE_MID, BUTTON_DOWN);
        send_item(CMD_SAMPLE, 'h2aa, 'h155, BUTTON_DOWN);
        send_item(CMD_SAMPLE, 'h155, 'h2aa, BUTTON_DOWN);
        send_item(CMD_CALIBRATE, 700, 300, BUTTON_UP);    // hold count kept
        send_item(CMD_SAMPLE, 700, 300, BUTTON_DOWN);
        send_item(CMD_SAMPLE, 690, 310, BUTTON_UP);
        last_x = 690;
        last_y = 310;
        aim_x  = 700;
        aim_y  = 300;

        // Zero threshold and dead zone: moved always set
        wait_idle();
        set_config(0, 0);
        send_item(CMD_SAMPLE, 700, 300, BUTTON_UP);
        send_item(CMD_SAMPLE, 700, 300, BUTTON_UP);
        send_item(CMD_CALIBRATE, 700, 300, BUTTON_UP);

        // Phase 0: moderate settings, one long press to saturate the count
        wait_idle();
        set_config($urandom_range(60, 5), $urandom_range(100, 5));
        long_press_due = 1'b1;
        run_phase(PHASE_ITEMS);

        // Phase 1: zero settings, long receiver hold-off to fill the pipeline
        wait_idle();
        set_config(0, 0);
        hold_off_req <= 1'b1;
        run_phase(PHASE_ITEMS);

        // Phase 2: all-ones writes (unused dead zone bit set), no idling
        wait_idle();
        set_config(CFG_DATA_MAX, CFG_DATA_MAX);
        quiet_phase <= 1'b1;
        run_phase(PHASE_ITEMS);

        // Phase 3: full-range random settings, another long press
        wait_idle();
        set_config($urandom_range(CFG_DATA_MAX), $urandom_range(CFG_DATA_MAX));
        quiet_phase    <= 1'b0;
        long_press_due = 1'b1;
        run_phase(PHASE_ITEMS);

        // Phase 4: small random settings
        wait_idle();
        set_config($urandom_range(20), $urandom_range(30));
        run_phase(PHASE_ITEMS);

        wait_idle();
        if (mismatch_count == 0)
            $display("analog_stick_conditioner_top_test OK");
        else
            $display("analog_stick_conditioner_top_test NOT OK");
        $finish;
    end

endmodule

FILE: analog_stick_conditioner_top.f
+incdir+hw/rtl
hw/rtl/asc_pkg.sv
hw/rtl/analog_stick_conditioner_top.sv
dv/analog_stick_conditioner_checker.sv
dv/analog_stick_conditioner_top_test.sv
